// File: sv/jse_pkg.sv
// Shared types, character codes and the byte sequencer function for the JSON string escaper.
package jse_pkg;

  localparam logic [7:0] QuoteCh  = 8'h22;
  localparam logic [7:0] BslashCh = 8'h5C;
  localparam logic [7:0] DelCh    = 8'h7F;
  localparam logic [7:0] CtrlTop  = 8'h20;
  localparam logic [7:0] ZeroCh   = 8'h30;
  localparam logic [7:0] UpperACh = 8'h41;
  localparam logic [7:0] LowerUCh = 8'h75;
  localparam logic [7:0] LowerNCh = 8'h6E;
  localparam logic [7:0] LowerLCh = 8'h6C;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_NULL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_PLAIN = 3'd0,
    OP_BSESC = 3'd1,
    OP_UESC  = 3'd2,
    OP_EMPTY = 3'd3,
    OP_NULL  = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       first;
    logic [2:0] last_idx;
  } desc_t;

  localparam int unsigned DescW = $bits(desc_t);

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ZeroCh + {4'b0, nib};
    end else begin
      r = UpperACh + {4'b0, nib} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_at(input desc_t d, input logic [2:0] idx);
    logic [2:0] pos;
    logic [7:0] r;
    pos = idx - {2'b0, d.first};
    r   = QuoteCh;
    unique case (d.op)
      OP_EMPTY: r = QuoteCh;
      OP_NULL: begin
        unique case (idx[1:0])
          2'd0:    r = LowerNCh;
          2'd1:    r = LowerUCh;
          default: r = LowerLCh;
        endcase
      end
      OP_PLAIN: begin
        if (!(d.first && idx == 3'd0) && pos == 3'd0) r = d.data;
      end
      OP_BSESC: begin
        if (!(d.first && idx == 3'd0)) begin
          if (pos == 3'd0) r = BslashCh;
          else if (pos == 3'd1) r = d.data;
        end
      end
      OP_UESC: begin
        if (!(d.first && idx == 3'd0)) begin
          unique case (pos)
            3'd0:    r = BslashCh;
            3'd1:    r = LowerUCh;
            3'd2:    r = ZeroCh;
            3'd3:    r = ZeroCh;
            3'd4:    r = hex_char(d.data[7:4]);
            3'd5:    r = hex_char(d.data[3:0]);
            default: r = QuoteCh;
          endcase
        end
      end
      default: r = QuoteCh;
    endcase
    return r;
  endfunction

endpackage

// File: sv/jse_front.sv
// Front end: classifies each input item into an expansion descriptor.
module jse_front (
  input  logic [1:0]     kind_i,
  input  logic [7:0]     in_byte_i,
  input  logic           is_first_i,
  input  logic           is_last_i,
  output logic           defined_o,
  output jse_pkg::desc_t desc_o
);
  import jse_pkg::*;

  logic [2:0] body_last;

  always_comb begin
    desc_o    = '0;
    defined_o = 1'b1;
    body_last = 3'd0;
    desc_o.data  = in_byte_i;
    unique case (kind_e'(kind_i))
      KIND_EMPTY: begin
        desc_o.op       = OP_EMPTY;
        desc_o.last_idx = 3'd1;
      end
      KIND_NULL: begin
        desc_o.op       = OP_NULL;
        desc_o.last_idx = 3'd3;
      end
      KIND_DATA: begin
        desc_o.first = is_first_i;
        if (in_byte_i < CtrlTop || in_byte_i == DelCh) begin
          desc_o.op = OP_UESC;
          body_last = 3'd5;
        end else if (in_byte_i == QuoteCh || in_byte_i == BslashCh) begin
          desc_o.op = OP_BSESC;
          body_last = 3'd1;
        end else begin
          desc_o.op = OP_PLAIN;
          body_last = 3'd0;
        end
        desc_o.last_idx = body_last + {2'b0, is_first_i} + {2'b0, is_last_i};
      end
      default: defined_o = 1'b0;
    endcase
  end

endmodule

// File: sv/jse_fifo.sv
// Short descriptor queue between the front and back ends.
module jse_fifo #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] head_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: sv/jse_back.sv
// Back end: expands descriptors to escaped bytes in an output reg, one per unstalled cycle.
module jse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  jse_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  input  logic           out_ready_i
);
  import jse_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [2:0] step_q, step_d;
  logic       load, at_end;

  assign load   = head_valid_i && (!valid_q || out_ready_i);
  assign at_end = (step_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    step_d  = step_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = byte_at(head_i, step_q);
      last_d  = at_end;
      step_d  = at_end ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 3'd0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// File: sv/json_string_escaper_core.sv
// Top level of the JSON string escaper: front classifier, descriptor queue, byte expander.
// An item's first byte passes through the queue and then the output register.
// The expander emits one output byte per cycle while m_axis_tready allows; an item expands
// to 1 to 8 bytes, so plain bytes stream at one item per cycle when the output is not stalled.
// Input is taken while the descriptor queue has room. Kind 3 is accepted and dropped.
// Reset empties the queue and the output register; no clearing pass.
module json_string_escaper_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] in_byte, [8] is_first, [15:9] zero
  input  logic        s_axis_tlast,  // is_last
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast   // last_of_run
);
  import jse_pkg::*;

  desc_t      front_desc, head_desc;
  logic       defined, q_full, q_empty, pop;
  logic [DescW-1:0] head_bits;

  jse_front u_front (
    .kind_i     (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[7:0]),
    .is_first_i (s_axis_tdata[8]),
    .is_last_i  (s_axis_tlast),
    .defined_o  (defined),
    .desc_o     (front_desc)
  );

  assign s_axis_tready = !q_full;

  jse_fifo #(
    .Width (DescW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid && defined),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_bits)
  );

  assign head_desc = desc_t'(head_bits);

  jse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

endmodule

// File: verif/tb_json_string_escaper_core.sv
// Self-checking testbench for json_string_escaper_core: directed table, then random strings.
module tb_json_string_escaper_core;
  import jse_pkg::*;

  localparam logic [1:0] KIND_UNDEF = 2'd3;
  localparam int NumRows = 20;
  localparam int ItemTarget = 90;

  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } text_byte_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic        first;
    logic        last;
    int          n_typed;
    logic [63:0] typed;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  text_byte_t  escaped_text[$];
  stim_row_t   rows[NumRows];
  int          mismatches = 0;
  int          ready_hold = 0;
  bit          no_idle = 1'b0;

  json_string_escaper_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ZeroCh + 8'(nib);
    end
    return UpperACh + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1: return 8'($urandom_range(0, 31));
      2: return DelCh;
      3: return ($urandom_range(0, 1) != 0) ? QuoteCh : BslashCh;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_text(input logic [7:0] ch);
    escaped_text.push_back('{ch: ch, tail: 1'b0});
  endtask

  task automatic escape_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic first, input logic last);
    int n_before;
    text_byte_t tail_byte;
    n_before = escaped_text.size();
    case (kind)
      KIND_EMPTY: begin
        add_text(QuoteCh);
        add_text(QuoteCh);
      end
      KIND_NULL: begin
        add_text(LowerNCh);
        add_text(LowerUCh);
        add_text(LowerLCh);
        add_text(LowerLCh);
      end
      KIND_DATA: begin
        if (first) add_text(QuoteCh);
        if (ch < CtrlTop || ch == DelCh) begin
          add_text(BslashCh);
          add_text(LowerUCh);
          add_text(ZeroCh);
          add_text(ZeroCh);
          add_text(nibble_ascii(ch[7:4]));
          add_text(nibble_ascii(ch[3:0]));
        end else begin
          if (ch == QuoteCh || ch == BslashCh) add_text(BslashCh);
          add_text(ch);
        end
        if (last) add_text(QuoteCh);
      end
      default: begin
      end
    endcase
    if (escaped_text.size() > n_before) begin
      tail_byte = escaped_text.pop_back();
      tail_byte.tail = 1'b1;
      escaped_text.push_back(tail_byte);
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [7:0] ch, input logic first,
                           input logic last, input int n_typed, input logic [63:0] typed);
    int gap;
    int i;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, first, ch};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (n_typed < 0) begin
      escape_item(kind, ch, first, last);
    end else begin
      for (i = 0; i < n_typed; i++) begin
        escaped_text.push_back('{ch: typed[i*8 +: 8], tail: (i == n_typed - 1)});
      end
    end
  endtask

  task automatic wait_drained();
    while (escaped_text.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    text_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (escaped_text.size() == 0) begin
          $error("out_byte: nothing expected, got %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = escaped_text.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("out_byte: expected %h, got %h", want.ch, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.tail) begin
            $error("last_of_run: expected %b, got %b", want.tail, m_axis_tlast);
            mismatches++;
          end
        end
        ready_hold = draw_wait();
      end
      if (ready_hold > 0) begin
        m_axis_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    int sent;
    int len;
    int j;
    bit paused;
    logic [1:0] noise_kind;

    rows[0]  = '{KIND_EMPTY, 8'h00, 1'b0, 1'b0, 2, 64'h2222};
    rows[1]  = '{KIND_NULL,  8'h00, 1'b0, 1'b0, 4, 64'h6C6C756E};
    rows[2]  = '{KIND_UNDEF, 8'h00, 1'b0, 1'b0, 0, 64'h0};
    rows[3]  = '{KIND_DATA,  8'h00, 1'b1, 1'b1, 8, 64'h22303030_30755C22};
    rows[4]  = '{KIND_DATA,  8'hFF, 1'b1, 1'b1, 3, 64'h22FF22};
    rows[5]  = '{KIND_DATA,  8'h1F, 1'b1, 1'b0, -1, 64'h0};
    rows[6]  = '{KIND_DATA,  8'h20, 1'b0, 1'b0, -1, 64'h0};
    rows[7]  = '{KIND_DATA,  8'h7F, 1'b0, 1'b0, -1, 64'h0};
    rows[8]  = '{KIND_DATA,  8'h7E, 1'b0, 1'b0, -1, 64'h0};
    rows[9]  = '{KIND_DATA,  8'h22, 1'b0, 1'b0, -1, 64'h0};
    rows[10] = '{KIND_DATA,  8'h5C, 1'b0, 1'b1, -1, 64'h0};
    rows[11] = '{KIND_DATA,  8'h41, 1'b1, 1'b0, -1, 64'h0};
    rows[12] = '{KIND_DATA,  8'h0A, 1'b0, 1'b1, -1, 64'h0};
    rows[13] = '{KIND_DATA,  8'h80, 1'b1, 1'b1, -1, 64'h0};
    rows[14] = '{KIND_EMPTY, 8'hFF, 1'b1, 1'b1, 2, 64'h2222};
    rows[15] = '{KIND_NULL,  8'hFF, 1'b1, 1'b1, 4, 64'h6C6C756E};
    rows[16] = '{KIND_UNDEF, 8'hAA, 1'b1, 1'b1, 0, 64'h0};
    rows[17] = '{KIND_DATA,  8'h0F, 1'b1, 1'b0, -1, 64'h0};
    rows[18] = '{KIND_DATA,  8'h19, 1'b0, 1'b0, -1, 64'h0};
    rows[19] = '{KIND_DATA,  8'h5B, 1'b0, 1'b1, -1, 64'h0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      send_item(rows[r].kind, rows[r].ch, rows[r].first, rows[r].last,
                rows[r].n_typed, rows[r].typed);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < ItemTarget) begin
      no_idle = (sent >= 45 && sent < 75);
      if (sent >= 80 && !paused) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        paused = 1'b1;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 6) == 0) begin
        noise_kind = 2'($urandom_range(0, 3));
        send_item(noise_kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), -1, 64'h0);
        if (noise_kind != KIND_UNDEF) sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) begin
          send_item(KIND_DATA, random_char(), (j == 0), (j == len - 1), -1, 64'h0);
        end
        sent += len;
      end
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_json_string_escaper_core OK");
    end else begin
      $display("tb_json_string_escaper_core NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_json_string_escaper_core NOT OK");
    $finish;
  end

endmodule

// File: json_string_escaper_core.f
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_fifo.sv
sv/jse_back.sv
sv/json_string_escaper_core.sv
verif/tb_json_string_escaper_core.sv
